>>> rtl/vip_pkg.sv
`timescale 1ns / 1ps
package vip_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int IN_OFFSET   = 0;
  localparam int OUT_OFFSET  = 0;
  localparam int DIV_BITS    = 32 + FRAC_BITS;  // quotient bits of |num| << FRAC_BITS

  localparam longint ONE_Q = longint'(1) << FRAC_BITS;
  localparam logic signed [31:0] C_ONE  = 32'(ONE_Q);
  localparam logic signed [31:0] C_0P1  = 32'((ONE_Q * 2 + 10) / 20);
  localparam logic signed [31:0] C_0P02 = 32'((ONE_Q * 4 + 100) / 200);
  localparam logic signed [31:0] C_0P16 = 32'((ONE_Q * 32 + 100) / 200);
  localparam logic signed [31:0] C_0P2  = 32'((ONE_Q * 4 + 10) / 20);
  localparam logic signed [31:0] C_1P16 = 32'((ONE_Q * 232 + 100) / 200);
  localparam logic signed [31:0] C_3    = 32'(ONE_Q * 3);

  typedef enum logic [3:0] {
    RULE_NDVI  = 4'd0,
    RULE_NDVI2 = 4'd1,
    RULE_GVMI  = 4'd2,
    RULE_VARI  = 4'd3,
    RULE_OSAVI = 4'd4,
    RULE_MCARI = 4'd5,
    RULE_TCARI = 4'd6,
    RULE_DIFF  = 4'd7,
    RULE_SCALE = 4'd8,
    RULE_RATIO = 4'd9
  } rule_t;

  typedef enum logic [3:0] {
    REG_RULE_MODE  = 4'd0,
    REG_INVALID    = 4'd1,
    REG_FLAG       = 4'd2,
    REG_MIN        = 4'd3,
    REG_MAX        = 4'd4,
    REG_EPS        = 4'd5,
    REG_IN_GAIN    = 4'd6,
    REG_OUT_GAIN   = 4'd7
  } reg_idx_t;

  // intermediate terms carried down the front pipeline
  typedef struct packed {
    logic signed [31:0] b0, b1, b2, b3;
    logic signed [31:0] s10, a10, t, u, d12, a12, d21, d20, a23;
    logic signed [31:0] gnum, gdiv, vdiv, onum, odiv, p, t6;
    logic signed [31:0] t5, u6, mnum, tdf;
    logic               inv;
  } arith_t;

  typedef struct packed {
    logic [32:0]         r;
    logic [DIV_BITS-1:0] n;
    logic [DIV_BITS-1:0] q;
    logic [31:0]         d;
    logic                neg;
    logic                skip;
    logic                inv;
  } div_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat32(64'(a) + 64'(b));
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat32(64'(a) - 64'(b));
  endfunction

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + (64'sd1 <<< (FRAC_BITS - 1));
    return sat32(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] norm_band(input logic [SAMPLE_BITS-1:0] s,
                                                   input logic [31:0] gain);
    logic signed [63:0] d;
    logic signed [63:0] p;
    d = 64'(sat32(64'($signed({1'b0, s})) - 64'(IN_OFFSET)));
    p = d * $signed({32'd0, gain}) + (64'sd1 <<< (FRAC_BITS - 1));
    return sat32(p >>> FRAC_BITS);
  endfunction

endpackage

>>> rtl/vegetation_index_pixel_unit.sv
`timescale 1ns / 1ps
// Vegetation index pixel unit.
// s_* : one pixel per transfer, four raw band samples in s_tdata.
// m_* : one result per pixel, index value in m_tdata, invalid flag in m_tuser.
// cfg_*: register writes (index, data); always ready. Write only while idle.
// Each band is normalized by in_gain, the selected rule forms a numerator and
// divisor, the quotient is clamped to [min, max], scaled by out_gain and
// rounded half up. A pixel with a used band equal to invalid_value returns
// flag_value with the invalid flag set.
// The path from input transfer to result has six stages of band
// normalization and rule arithmetic, one divider setup stage, 48 restoring
// divider stages (one quotient bit each), then clamp, output multiply and
// rounding stages. One pixel per cycle is accepted when the receiver is ready.
// When m_tready is low with a result waiting, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated.
// Reset (rst, synchronous) empties the pipeline and loads register defaults.
module vegetation_index_pixel_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [4*vip_pkg::SAMPLE_BITS-1:0] s_tdata,  // band_zero, band_one, band_two, band_three
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [31:0]                      m_tdata,   // pixel_value
  output logic [0:0]                       m_tuser,   // pixel_invalid
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [3:0]                       cfg_index,
  input  logic [31:0]                      cfg_data
);
  import vip_pkg::*;

  logic [3:0]         rule_mode;
  logic [15:0]        invalid_value;
  logic signed [31:0] flag_value;
  logic signed [31:0] min_value;
  logic signed [31:0] max_value;
  logic [30:0]        eps;
  logic [31:0]        in_gain;
  logic signed [31:0] out_gain;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_mode     <= RULE_NDVI;
      invalid_value <= '0;
      flag_value    <= '0;
      min_value     <= '0;
      max_value     <= 32'sh7FFF_FFFF;
      eps           <= '0;
      in_gain       <= 32'(ONE_Q);
      out_gain      <= C_ONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RULE_MODE: rule_mode     <= cfg_data[3:0];
        REG_INVALID:   invalid_value <= cfg_data[15:0];
        REG_FLAG:      flag_value    <= cfg_data;
        REG_MIN:       min_value     <= cfg_data;
        REG_MAX:       max_value     <= cfg_data;
        REG_EPS:       eps           <= cfg_data[30:0];
        REG_IN_GAIN:   in_gain       <= cfg_data;
        REG_OUT_GAIN:  out_gain      <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // front arithmetic stages 1..5
  arith_t x1, x2, x3, x4, x5;
  arith_t n1, n2, n3, n4, n5;
  logic   v1, v2, v3, v4, v5, v6;

  logic [SAMPLE_BITS-1:0] raw0, raw1, raw2, raw3;
  assign raw0 = s_tdata[SAMPLE_BITS-1:0];
  assign raw1 = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign raw2 = s_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
  assign raw3 = s_tdata[4*SAMPLE_BITS-1:3*SAMPLE_BITS];

  always_comb begin
    logic m0, m1, m2, m3;
    n1    = '0;
    n1.b0 = norm_band(raw0, in_gain);
    n1.b1 = norm_band(raw1, in_gain);
    n1.b2 = norm_band(raw2, in_gain);
    n1.b3 = norm_band(raw3, in_gain);
    m0 = (raw0 == invalid_value);
    m1 = (raw1 == invalid_value);
    m2 = (raw2 == invalid_value);
    m3 = (raw3 == invalid_value);
    case (rule_mode)
      RULE_SCALE:                        n1.inv = m0;
      RULE_NDVI2:                        n1.inv = m0 | m1 | m2 | m3;
      RULE_VARI, RULE_MCARI, RULE_TCARI: n1.inv = m0 | m1 | m2;
      default:                           n1.inv = m0 | m1;
    endcase
  end

  always_comb begin
    n2     = x1;
    n2.s10 = qsub(x1.b1, x1.b0);
    n2.a10 = qadd(x1.b1, x1.b0);
    n2.t   = qadd(x1.b0, C_0P1);
    n2.u   = qadd(x1.b1, C_0P02);
    n2.d12 = qsub(x1.b1, x1.b2);
    n2.a12 = qadd(x1.b1, x1.b2);
    n2.d21 = qsub(x1.b2, x1.b1);
    n2.d20 = qsub(x1.b2, x1.b0);
    n2.a23 = qadd(x1.b2, x1.b3);
  end

  always_comb begin
    n3      = x2;
    n3.gnum = qsub(x2.t, x2.u);
    n3.gdiv = qadd(x2.t, x2.u);
    n3.vdiv = qsub(x2.a12, x2.b0);
    n3.onum = qmul(C_1P16, x2.s10);
    n3.odiv = qadd(x2.a10, C_0P16);
    n3.p    = qmul(C_0P2, x2.d20);
    n3.t6   = qmul(x2.d21, x2.b1);
  end

  always_comb begin
    n4    = x3;
    n4.t5 = qsub(x3.d21, x3.p);
    n4.u6 = qmul(x3.p, x3.b2);
  end

  always_comb begin
    n5      = x4;
    n5.mnum = qmul(x4.t5, x4.b2);
    n5.tdf  = qsub(x4.t6, x4.u6);
  end

  // stage 6: rule select
  logic signed [31:0] num6, div6, num_n, div_n;
  logic               do6, do_n, inv6;

  always_comb begin
    num_n = '0;
    div_n = C_ONE;
    do_n  = 1'b1;
    case (rule_mode)
      RULE_NDVI:  begin num_n = x5.s10;  div_n = x5.a10;  end
      RULE_NDVI2: begin num_n = x5.s10;  div_n = x5.a23;  end
      RULE_GVMI:  begin num_n = x5.gnum; div_n = x5.gdiv; end
      RULE_VARI:  begin num_n = x5.d12;  div_n = x5.vdiv; end
      RULE_OSAVI: begin num_n = x5.onum; div_n = x5.odiv; end
      RULE_MCARI: begin num_n = x5.mnum; div_n = x5.b1;   end
      RULE_TCARI: begin num_n = qmul(C_3, x5.tdf); div_n = x5.b1; end
      RULE_DIFF:  begin num_n = x5.s10;  div_n = C_ONE;   end
      RULE_SCALE: begin num_n = x5.b0;   div_n = C_ONE;   end
      RULE_RATIO: begin num_n = x5.b0;   div_n = x5.b1;   end
      default:    do_n = 1'b0;
    endcase
  end

  // divider setup
  div_t dv [0:DIV_BITS];
  logic dvv [0:DIV_BITS];
  div_t dv0_n;

  always_comb begin
    logic signed [32:0] e;
    e           = $signed({2'b00, eps});
    dv0_n       = '0;
    dv0_n.skip  = !(do6 && (33'(div6) > e || 33'(div6) < -e));
    dv0_n.neg   = num6[31] ^ div6[31];
    dv0_n.n     = {(num6[31] ? 32'(-num6) : 32'(num6)), {FRAC_BITS{1'b0}}};
    dv0_n.d     = div6[31] ? 32'(-div6) : 32'(div6);
    dv0_n.inv   = inv6;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= n1; x2 <= n2; x3 <= n3; x4 <= n4; x5 <= n5;
      num6 <= num_n; div6 <= div_n; do6 <= do_n; inv6 <= x5.inv;
      dv[0] <= dv0_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      dvv[0] <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5;
      dvv[0] <= v6;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    div_t step;
    always_comb begin
      logic [32:0] rs;
      step = dv[k];
      rs   = {dv[k].r[31:0], dv[k].n[DIV_BITS-1]};
      step.n = {dv[k].n[DIV_BITS-2:0], 1'b0};
      if (rs >= {1'b0, dv[k].d}) begin
        step.r = rs - {1'b0, dv[k].d};
        step.q = {dv[k].q[DIV_BITS-2:0], 1'b1};
      end else begin
        step.r = rs;
        step.q = {dv[k].q[DIV_BITS-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (en) dv[k+1] <= step;
    end
    always_ff @(posedge clk) begin
      if (rst) dvv[k+1] <= 1'b0;
      else if (en) dvv[k+1] <= dvv[k];
    end
  end

  // clamp
  logic signed [31:0] idx, idx_n;
  logic               inv_c, vc;

  always_comb begin
    logic signed [DIV_BITS:0] qs;
    qs = dv[DIV_BITS].neg ? -$signed({1'b0, dv[DIV_BITS].q})
                          :  $signed({1'b0, dv[DIV_BITS].q});
    idx_n = dv[DIV_BITS].skip ? min_value : sat32(64'(qs));
    if (idx_n < min_value)      idx_n = min_value;
    else if (idx_n > max_value) idx_n = max_value;
  end

  // output scale
  logic signed [63:0] prod;
  logic               inv_p, vp;
  logic signed [31:0] res_n;

  always_comb begin
    logic signed [63:0] r;
    r     = (prod + (64'sd1 <<< (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
    res_n = sat32(r + 64'(OUT_OFFSET));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx   <= idx_n;
      inv_c <= dv[DIV_BITS].inv;
      prod  <= 64'(idx) * 64'(out_gain);
      inv_p <= inv_c;
      m_tdata    <= inv_p ? flag_value : res_n;
      m_tuser[0] <= inv_p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc       <= 1'b0;
      vp       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vc       <= dvv[DIV_BITS];
      vp       <= vc;
      m_tvalid <= vp;
    end
  end

endmodule

>>> tb/tb_vegetation_index_pixel_unit.sv
`timescale 1ns / 1ps
module tb_vegetation_index_pixel_unit;
  import vip_pkg::*;

  localparam int LATENCY   = 58;
  localparam int WDOG_LIMIT = 4000;

  typedef struct packed {
    logic [15:0] b3, b2, b1, b0;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               invalid;
  } pix_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [0:0] m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  vegetation_index_pixel_unit u_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
    .m_tdata, .m_tuser, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // shadow of the register file
  logic [3:0]         sh_rule;
  logic [15:0]        sh_invalid;
  logic signed [31:0] sh_flag, sh_min, sh_max, sh_out_gain;
  logic [30:0]        sh_eps;
  logic [31:0]        sh_in_gain;

  pixel_t      pixel_queue[$];
  pix_result_t expected_pixels[$];
  int          errors = 0;
  int          in_idle_pct = 0;
  int          out_idle_pct = 0;
  longint      idle_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic longint sat_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor(v / 2^k)
  function automatic longint floor_div2(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return sat_q(floor_div2(a * b + (64'sd1 <<< 15), 16));
  endfunction

  function automatic longint scale_band(logic [15:0] s);
    longint d;
    d = longint'(s);
    return sat_q(floor_div2(d * longint'(sh_in_gain) + (64'sd1 <<< 15), 16));
  endfunction

  function automatic pix_result_t compute_index(pixel_t px);
    logic [15:0] raw[4];
    longint b[4];
    longint num, dvs, idx, t, u, prod, k01, k002, k016, k02, k116, k3, lim;
    int nused;
    bit do_div;
    pix_result_t r;
    k01 = (65536 * 2 + 10) / 20;
    k002 = (65536 * 4 + 100) / 200;
    k016 = (65536 * 32 + 100) / 200;
    k02 = (65536 * 4 + 10) / 20;
    k116 = (65536 * 232 + 100) / 200;
    k3 = 65536 * 3;
    raw[0] = px.b0; raw[1] = px.b1; raw[2] = px.b2; raw[3] = px.b3;
    for (int i = 0; i < 4; i++) b[i] = scale_band(raw[i]);
    case (sh_rule)
      RULE_SCALE: nused = 1;
      RULE_NDVI2: nused = 4;
      RULE_VARI, RULE_MCARI, RULE_TCARI: nused = 3;
      default: nused = 2;
    endcase
    for (int i = 0; i < nused; i++)
      if (raw[i] == sh_invalid) begin
        r.value = sh_flag;
        r.invalid = 1'b1;
        return r;
      end
    num = 0; dvs = 0; do_div = 1;
    case (sh_rule)
      RULE_NDVI: begin
        num = sat_q(b[1] - b[0]); dvs = sat_q(b[1] + b[0]);
      end
      RULE_NDVI2: begin
        num = sat_q(b[1] - b[0]); dvs = sat_q(b[2] + b[3]);
      end
      RULE_GVMI: begin
        t = sat_q(b[0] + k01); u = sat_q(b[1] + k002);
        num = sat_q(t - u); dvs = sat_q(t + u);
      end
      RULE_VARI: begin
        num = sat_q(b[1] - b[2]); dvs = sat_q(sat_q(b[1] + b[2]) - b[0]);
      end
      RULE_OSAVI: begin
        num = fx_mul(k116, sat_q(b[1] - b[0]));
        dvs = sat_q(sat_q(b[1] + b[0]) + k016);
      end
      RULE_MCARI: begin
        t = sat_q(sat_q(b[2] - b[1]) - fx_mul(k02, sat_q(b[2] - b[0])));
        num = fx_mul(t, b[2]); dvs = b[1];
      end
      RULE_TCARI: begin
        t = fx_mul(sat_q(b[2] - b[1]), b[1]);
        u = fx_mul(fx_mul(k02, sat_q(b[2] - b[0])), b[2]);
        num = fx_mul(k3, sat_q(t - u)); dvs = b[1];
      end
      RULE_DIFF: begin
        num = sat_q(b[1] - b[0]); dvs = 65536;
      end
      RULE_SCALE: begin
        num = b[0]; dvs = 65536;
      end
      RULE_RATIO: begin
        num = b[0]; dvs = b[1];
      end
      default: do_div = 0;
    endcase
    lim = longint'(sh_eps);
    idx = sh_min;
    if (do_div && (dvs > lim || dvs < -lim)) idx = sat_q((num * 65536) / dvs);
    if (idx < sh_min) idx = sh_min;
    else if (idx > sh_max) idx = sh_max;
    prod = idx * longint'(sh_out_gain) + (64'sd1 <<< 31);
    r.value = 32'(sat_q(floor_div2(prod, 32) + OUT_OFFSET));
    r.invalid = 1'b0;
    return r;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_RULE_MODE: sh_rule = val[3:0];
      REG_INVALID:   sh_invalid = val[15:0];
      REG_FLAG:      sh_flag = val;
      REG_MIN:       sh_min = val;
      REG_MAX:       sh_max = val;
      REG_EPS:       sh_eps = val[30:0];
      REG_IN_GAIN:   sh_in_gain = val;
      REG_OUT_GAIN:  sh_out_gain = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic enqueue_pixel(pixel_t px);
    pixel_queue = {pixel_queue, px};
  endtask

  // wait for the pipeline to drain, then let it settle
  task automatic drain();
    while (pixel_queue.size() != 0 || s_tvalid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_random(int n);
    pixel_t px;
    for (int i = 0; i < n; i++) begin
      px.b0 = rand_sample(); px.b1 = rand_sample();
      px.b2 = rand_sample(); px.b3 = rand_sample();
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: px.b0 = sh_invalid;
          1: px.b1 = sh_invalid;
          2: px.b2 = sh_invalid;
          default: px.b3 = sh_invalid;
        endcase
      end
      enqueue_pixel(px);
    end
  endtask

  task automatic random_settings();
    logic signed [31:0] lo, hi;
    write_reg(REG_RULE_MODE, $urandom_range(0, 11) == 0 ? $urandom_range(10, 15)
                                                        : $urandom_range(0, 9));
    write_reg(REG_INVALID, $urandom_range(0, 1) ? 32'($urandom_range(0, 15)) : $urandom);
    write_reg(REG_FLAG, $urandom);
    case ($urandom_range(0, 3))
      0: begin lo = 32'sh8000_0000; hi = 32'sh7FFF_FFFF; end
      1: begin lo = -($urandom_range(0, 4) <<< 16); hi = $urandom_range(0, 4) <<< 16; end
      2: begin lo = $urandom; hi = $urandom; end
      default: begin lo = -32'sd65536; hi = 32'sd65536; end
    endcase
    write_reg(REG_MIN, lo);
    write_reg(REG_MAX, hi);
    write_reg(REG_EPS, $urandom_range(0, 1) ? 32'($urandom_range(0, 700)) : ($urandom >> 1));
    case ($urandom_range(0, 3))
      0: write_reg(REG_IN_GAIN, 32'h0001_0000);
      1: write_reg(REG_IN_GAIN, $urandom_range(0, 32'h0000_1000));
      2: write_reg(REG_IN_GAIN, $urandom);
      default: write_reg(REG_IN_GAIN, $urandom_range(16, 1024));
    endcase
    case ($urandom_range(0, 2))
      0: write_reg(REG_OUT_GAIN, 32'h0001_0000);
      1: write_reg(REG_OUT_GAIN, $urandom);
      default: write_reg(REG_OUT_GAIN, 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16);
    endcase
  endtask

  // remember whether the current item was taken at the last rising edge
  logic s_tready_q = 1'b0;
  always @(posedge clk) s_tready_q <= s_tvalid && s_tready;

  // driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready_q) begin
      if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= pixel_queue.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= rst ? 1'b0 : ($urandom_range(0, 99) >= out_idle_pct);
  end

  // monitor
  always @(posedge clk) begin
    pix_result_t exp_r;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_pixels = {expected_pixels, compute_index(pixel_t'(s_tdata))};
        idle_cycles = 0;
      end else if (!(m_tvalid && m_tready) && !(cfg_valid && cfg_ready)) begin
        idle_cycles++;
      end
      if (m_tvalid && m_tready) begin
        idle_cycles = 0;
        if (expected_pixels.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h/%b", m_tdata, m_tuser);
        end else begin
          exp_r = expected_pixels.pop_front();
          if (m_tdata !== exp_r.value || m_tuser[0] !== exp_r.invalid) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: value exp %h got %h, invalid exp %b got %b",
                       exp_r.value, m_tdata, exp_r.invalid, m_tuser[0]);
          end
        end
      end
      if (idle_cycles > WDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    pixel_t px;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    sh_rule = RULE_NDVI; sh_invalid = 0; sh_flag = 0; sh_min = 0;
    sh_max = 32'sh7FFF_FFFF; sh_eps = 0; sh_in_gain = 32'h0001_0000;
    sh_out_gain = 32'h0001_0000;

    // directed: every rule over extreme samples, invalid bands, clamp bounds
    write_reg(REG_INVALID, 32'h0000_1234);
    write_reg(REG_FLAG, 32'h8000_0000);
    write_reg(REG_MIN, 32'h8000_0000);
    for (int rule = 0; rule < 12; rule++) begin
      write_reg(REG_RULE_MODE, rule);
      px = '{b3: 16'hFFFF, b2: 16'h0000, b1: 16'hFFFF, b0: 16'h0001};
      enqueue_pixel(px);
      px = '{b3: 16'h0007, b2: 16'hFFFF, b1: 16'h0000, b0: 16'hFFFF};
      enqueue_pixel(px);
      if (rule < 4) begin
        px = '{b3: 16'h1234, b2: 16'h1234, b1: 16'h0005, b0: 16'h0009};
        enqueue_pixel(px);
      end
      drain();
    end
    // inverted bounds, huge gains, eps at its top
    write_reg(REG_RULE_MODE, RULE_RATIO);
    write_reg(REG_MIN, 32'h0002_0000);
    write_reg(REG_MAX, 32'hFFFF_0000);
    write_reg(REG_IN_GAIN, 32'hFFFF_FFFF);
    write_reg(REG_OUT_GAIN, 32'h7FFF_FFFF);
    write_reg(REG_EPS, 32'h7FFF_FFFF);
    px = '{b3: 0, b2: 0, b1: 16'h0003, b0: 16'hFFFF};
    enqueue_pixel(px);
    px = '{b3: 0, b2: 0, b1: 16'h0001, b0: 16'h0002};
    enqueue_pixel(px);
    drain();
    write_reg(REG_EPS, 0);
    write_reg(REG_OUT_GAIN, 32'h8000_0000);
    write_reg(REG_MIN, 32'h8000_0000);
    write_reg(REG_MAX, 32'h7FFF_FFFF);
    write_reg(REG_RULE_MODE, RULE_SCALE);
    enqueue_pixel(px);
    drain();

    // random phases under three idling profiles
    for (int ph = 0; ph < 27; ph++) begin
      if (ph < 9) begin in_idle_pct = 31; out_idle_pct = 74; end
      else if (ph < 18) begin in_idle_pct = 74; out_idle_pct = 31; end
      else begin in_idle_pct = 0; out_idle_pct = 0; end
      random_settings();
      push_random(50);
      drain();
    end

    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
